/* design/mss_pkg.sv */
// mss_pkg: shared codes, sequencer states and constants for the speed selector
// used by mirror_speed_select; no dependencies
package mss_pkg;

   typedef enum logic [1:0] {
      FN_ADD,
      FN_LOG,
      FN_SELECT,
      FN_RELEASE
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_CLR,
      ST_LOG_RD,
      ST_LOG_CHK,
      ST_LOG_MUL,
      ST_LOG_ADD,
      ST_LOG_WR,
      ST_SEL_ENT,
      ST_SEL_MEAN,
      ST_SEL_CMP,
      ST_SEL_END,
      ST_DIV,
      ST_RESPOND
   } state_type;

   // table size, tied to the 3-bit entry fields of the ports
   localparam int ENTRIES = 8;

   // result codes
   localparam logic [2:0] RC_OK   = 3'd0;
   localparam logic [2:0] RC_FULL = 3'd1;
   localparam logic [2:0] RC_SOON = 3'd2;
   localparam logic [2:0] RC_NONE = 3'd3;
   localparam logic [2:0] RC_BAD  = 3'd4;

   // entry status codes
   localparam logic [1:0] ES_NOT_TRIED = 2'd0;
   localparam logic [1:0] ES_FAILED    = 2'd1;
   localparam logic [1:0] ES_ACTIVE    = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_MAX_CONN = 2'd0;
   localparam logic [1:0] CSR_MIN_INT  = 2'd1;
   localparam logic [1:0] CSR_WINDOW   = 2'd2;

   localparam logic [3:0]  MAX_CONN_RST = 4'd5;
   localparam logic [15:0] MIN_INT_RST  = 16'd60;
   localparam logic [31:0] WINDOW_RST   = 32'd604800;

   localparam int SPEED_W = 40;
   localparam int DIV_W   = 60;
   localparam int STEP_W  = 6;
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_W - 1);

   localparam logic [19:0]        US_PER_S   = 20'd1000000;
   localparam logic [SPEED_W-1:0] SPEED_MAX  = 40'h7F_FFFF_FFFF;
   localparam logic [SPEED_W-1:0] SPEED_MIN  = 40'h80_0000_0000;
   localparam logic [SPEED_W-1:0] SPEED_NONE = 40'hFF_FFFF_FFFF;
   localparam logic [3:0]         CONN_SAT   = 4'd15;

endpackage

/* design/mirror_speed_select.sv */
// mirror_speed_select: source table with per-entry speed sample rings
// add clears its ring with a sweep; log sample runs the 60-step divider; select walks
// the table (ring walk, one read per cycle from the sample memory, then the shared
// divider for each mean)
// one word at a time; the next word is taken while the last result waits
// reset is synchronous: table empty, registers at their defaults; the sample
// memory needs no clearing since a ring is swept clean when its entry is added
module mirror_speed_select
   import mss_pkg::*;
#(
   parameter int SAMPLES = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_func,
   input  logic [2:0]                req_entry_id,
   input  logic                      req_initial_status,
   input  logic [31:0]               req_now_seconds,
   input  logic [39:0]               req_bytes_now,
   input  logic [39:0]               req_bytes_before,
   input  logic [31:0]               req_elapsed_us,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_status_code,
   output logic [2:0]                rsp_chosen_entry,
   output logic signed [39:0]        rsp_chosen_average,
   output logic signed [39:0]        rsp_logged_speed,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [31:0]               csr_wdata
);

   localparam int EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW    = $clog2(ENTRIES + 1);
   localparam int SLW   = $clog2(SAMPLES);
   localparam int CNTW  = $clog2(SAMPLES + 1);
   localparam int SW    = SPEED_W + CNTW;
   localparam int DEPTH = ENTRIES * SAMPLES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int MW    = 32 + SPEED_W;
   localparam logic [SLW-1:0] SLOT_LAST = SLW'(SAMPLES - 1);

   function automatic logic [AW-1:0] ring_addr(logic [EW-1:0] e, logic [SLW-1:0] s);
      ring_addr = AW'(AW'(e) * AW'(SAMPLES) + AW'(s));
   endfunction

   function automatic logic [SLW-1:0] slot_inc(logic [SLW-1:0] s);
      slot_inc = (s == SLOT_LAST) ? '0 : SLW'(s + 1'b1);
   endfunction

   function automatic logic [SLW-1:0] slot_dec(logic [SLW-1:0] s);
      slot_dec = (s == '0) ? SLOT_LAST : SLW'(s - 1'b1);
   endfunction

   state_type state_ff, state_in;

   logic [3:0]  max_conn_ff, max_conn_in;
   logic [15:0] min_int_ff, min_int_in;
   logic [31:0] window_ff, window_in;

   logic [CW-1:0]  count_ff, count_in;
   logic [1:0]     status_ff [ENTRIES];
   logic [1:0]     status_in [ENTRIES];
   logic [3:0]     conn_ff [ENTRIES];
   logic [3:0]     conn_in [ENTRIES];
   logic [SLW-1:0] newest_ff [ENTRIES];
   logic [SLW-1:0] newest_in [ENTRIES];

   func_type    func_ff, func_in;
   logic [2:0]  id_ff, id_in;
   logic [31:0] now_ff, now_in;
   logic [39:0] bn_ff, bn_in;
   logic [39:0] bb_ff, bb_in;
   logic [31:0] us_ff, us_in;

   logic [CW-1:0]    wk_ff, wk_in;
   logic [SLW-1:0]   slot_ff, slot_in;
   logic             pend_ff, pend_in;
   logic [SW-1:0]    sum_ff, sum_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic [39:0]      lo_ff, lo_in;
   logic [39:0]      hi_ff, hi_in;
   logic [31:0]      rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [31:0]      dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SPEED_W-1:0] best_ff, best_in;
   logic [EW-1:0]    pick_ff, pick_in;
   logic             found_ff, found_in;
   logic             untried_ff, untried_in;
   logic [2:0]       code_ff, code_in;
   logic [SPEED_W-1:0] spd_ff, spd_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_code_ff, rsp_code_in;
   logic [2:0]         rsp_entry_ff, rsp_entry_in;
   logic [SPEED_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic [SPEED_W-1:0] rsp_spd_ff, rsp_spd_in;

   logic [MW-1:0] sample_mem [DEPTH];
   logic [MW-1:0] rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [MW-1:0] mem_wdata;
   logic [AW-1:0] mem_raddr;

   // decoded conditions
   logic               accept;
   logic               id_bad;
   logic [EW-1:0]      id_idx;
   logic [EW-1:0]      walk_idx;
   logic [31:0]        rd_time;
   logic [SPEED_W-1:0] rd_speed;
   logic signed [33:0] win_limit;
   logic               too_old;
   logic [SW-1:0]      sum_new;
   logic [CNTW-1:0]    cnt_new;
   logic               mean_stop;
   logic signed [32:0] age;
   logic               too_soon;
   logic               walk_take;
   logic [SPEED_W-1:0] log_speed;
   logic [SPEED_W-1:0] mean_val;
   logic               div_ge;
   logic [32:0]        rem_shift;
   logic               rsp_free;

   assign accept    = req_valid && !req_stall;
   assign id_bad    = ({{CW{1'b0}}, id_ff} >= {3'b000, count_ff});
   assign id_idx    = EW'(id_ff);
   assign walk_idx  = EW'(wk_ff - 1'b1);
   assign rd_time   = rd_data_ff[MW-1:SPEED_W];
   assign rd_speed  = rd_data_ff[SPEED_W-1:0];
   assign win_limit = $signed({2'b00, now_ff}) - $signed({2'b00, window_ff});
   assign too_old   = $signed({2'b00, rd_time}) < win_limit;
   assign sum_new   = sum_ff + SW'($signed(rd_speed));
   assign cnt_new   = too_old ? cnt_ff : CNTW'(cnt_ff + 1'b1);
   assign mean_stop = pend_ff && (too_old || (cnt_new == CNTW'(SAMPLES)));
   assign age       = $signed({1'b0, now_ff}) - $signed({1'b0, rd_time});
   assign too_soon  = age < $signed({17'd0, min_int_ff});
   assign walk_take = (status_ff[walk_idx] != ES_FAILED)
                      && (conn_ff[walk_idx] <= max_conn_ff);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // saturate the quotient; zero elapsed time gives -1
   always_comb begin
      if (us_ff == '0) begin
         log_speed = SPEED_NONE;
      end else if (|quo_ff[DIV_W-1:SPEED_W-1]) begin
         log_speed = neg_ff ? SPEED_MIN : SPEED_MAX;
      end else begin
         log_speed = neg_ff ? SPEED_W'(-quo_ff[SPEED_W-1:0]) : quo_ff[SPEED_W-1:0];
      end
   end

   assign mean_val  = neg_ff ? SPEED_W'(-quo_ff[SPEED_W-1:0]) : quo_ff[SPEED_W-1:0];
   assign rem_shift = {rem_ff, quo_ff[DIV_W-1]};
   assign div_ge    = rem_shift >= {1'b0, dvs_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (func_type'(req_func))
                  FN_ADD:     state_in = ST_ADD_CLR;
                  FN_LOG:     state_in = ST_LOG_RD;
                  FN_SELECT:  state_in = ST_SEL_ENT;
                  FN_RELEASE: state_in = ST_RESPOND;
                  default:    state_in = ST_RESPOND;
               endcase
            end
         end
         ST_ADD_CLR: begin
            if (code_ff == RC_FULL) begin
               state_in = ST_RESPOND;
            end else if (slot_ff == SLOT_LAST) begin
               state_in = ST_RESPOND;
            end
         end
         ST_LOG_RD:  state_in = id_bad ? ST_RESPOND : ST_LOG_CHK;
         ST_LOG_CHK: begin
            if (too_soon) begin
               state_in = ST_RESPOND;
            end else if (us_ff == '0) begin
               state_in = ST_LOG_WR;
            end else begin
               state_in = ST_LOG_MUL;
            end
         end
         ST_LOG_MUL: state_in = ST_LOG_ADD;
         ST_LOG_ADD: state_in = ST_DIV;
         ST_LOG_WR:  state_in = ST_RESPOND;
         ST_SEL_ENT: begin
            if (wk_ff == '0 || status_ff[walk_idx] == ES_NOT_TRIED) begin
               state_in = ST_SEL_END;
            end else if (walk_take) begin
               state_in = ST_SEL_MEAN;
            end
         end
         ST_SEL_MEAN: begin
            if (mean_stop) begin
               state_in = (cnt_new == '0) ? ST_SEL_CMP : ST_DIV;
            end
         end
         ST_SEL_CMP: state_in = ST_SEL_ENT;
         ST_SEL_END: state_in = ST_RESPOND;
         ST_DIV: begin
            if (step_ff == DIV_LAST) begin
               state_in = (func_ff == FN_LOG) ? ST_LOG_WR : ST_SEL_CMP;
            end
         end
         ST_RESPOND: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake and memory control
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      mem_we    = 1'b0;
      mem_waddr = ring_addr(pick_ff, slot_ff);
      mem_wdata = '0;
      mem_raddr = ring_addr(walk_idx, slot_ff);
      unique case (state_ff)
         ST_ADD_CLR: begin
            mem_we = (code_ff != RC_FULL);
         end
         ST_LOG_RD: begin
            mem_raddr = ring_addr(id_idx, newest_ff[id_idx]);
         end
         ST_LOG_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ring_addr(id_idx, slot_inc(newest_ff[id_idx]));
            mem_wdata = {now_ff, log_speed};
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      max_conn_in = max_conn_ff;
      min_int_in  = min_int_ff;
      window_in   = window_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      conn_in     = conn_ff;
      newest_in   = newest_ff;
      func_in     = func_ff;
      id_in       = id_ff;
      now_in      = now_ff;
      bn_in       = bn_ff;
      bb_in       = bb_ff;
      us_in       = us_ff;
      wk_in       = wk_ff;
      slot_in     = slot_ff;
      pend_in     = pend_ff;
      sum_in      = sum_ff;
      cnt_in      = cnt_ff;
      neg_in      = neg_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      dvs_in      = dvs_ff;
      step_in     = step_ff;
      best_in     = best_ff;
      pick_in     = pick_ff;
      found_in    = found_ff;
      untried_in  = untried_ff;
      code_in     = code_ff;
      spd_in      = spd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_entry_in = rsp_entry_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_spd_in   = rsp_spd_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_MAX_CONN: max_conn_in = csr_wdata[3:0];
            CSR_MIN_INT:  min_int_in  = csr_wdata[15:0];
            CSR_WINDOW:   window_in   = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in    = func_type'(req_func);
               id_in      = req_entry_id;
               now_in     = req_now_seconds;
               bn_in      = req_bytes_now;
               bb_in      = req_bytes_before;
               us_in      = req_elapsed_us;
               code_in    = RC_OK;
               spd_in     = '0;
               pick_in    = '0;
               best_in    = SPEED_NONE;
               found_in   = 1'b0;
               untried_in = 1'b0;
               wk_in      = count_ff;
               slot_in    = '0;
               unique case (func_type'(req_func))
                  FN_ADD: begin
                     if (count_ff >= CW'(ENTRIES)) begin
                        code_in = RC_FULL;
                     end else begin
                        status_in[EW'(count_ff)] = {1'b0, req_initial_status};
                        conn_in[EW'(count_ff)]   = '0;
                        newest_in[EW'(count_ff)] = '0;
                        pick_in                  = EW'(count_ff);
                        count_in                 = CW'(count_ff + 1'b1);
                     end
                  end
                  FN_RELEASE: begin
                     if ({{CW{1'b0}}, req_entry_id} >= {3'b000, count_ff}) begin
                        code_in = RC_BAD;
                     end else if (conn_ff[EW'(req_entry_id)] != '0) begin
                        conn_in[EW'(req_entry_id)] = conn_ff[EW'(req_entry_id)] - 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD_CLR: begin
            slot_in = slot_inc(slot_ff);
         end
         ST_LOG_RD: begin
            if (id_bad) begin
               code_in = RC_BAD;
            end
         end
         ST_LOG_CHK: begin
            if (too_soon) begin
               code_in = RC_SOON;
            end else begin
               // byte delta magnitude parked in the quotient register
               logic [40:0] delta;
               delta  = {1'b0, bn_ff} - {1'b0, bb_ff};
               neg_in = delta[40];
               quo_in = DIV_W'(delta[40] ? 40'(-delta) : delta[39:0]);
            end
         end
         ST_LOG_MUL: begin
            lo_in = quo_ff[19:0] * US_PER_S;
            hi_in = quo_ff[39:20] * US_PER_S;
         end
         ST_LOG_ADD: begin
            quo_in  = DIV_W'({hi_ff, 20'd0}) + DIV_W'(lo_ff);
            dvs_in  = us_ff;
            rem_in  = '0;
            step_in = '0;
         end
         ST_LOG_WR: begin
            spd_in             = log_speed;
            newest_in[id_idx]  = slot_inc(newest_ff[id_idx]);
            status_in[id_idx]  = ES_ACTIVE;
         end
         ST_SEL_ENT: begin
            if (wk_ff != '0) begin
               if (status_ff[walk_idx] == ES_NOT_TRIED) begin
                  pick_in    = walk_idx;
                  found_in   = 1'b1;
                  untried_in = 1'b1;
               end else if (walk_take) begin
                  slot_in = newest_ff[walk_idx];
                  pend_in = 1'b0;
                  sum_in  = '0;
                  cnt_in  = '0;
               end else begin
                  wk_in = CW'(wk_ff - 1'b1);
               end
            end
         end
         ST_SEL_MEAN: begin
            // one read issued per cycle, the previous one evaluated
            slot_in = slot_dec(slot_ff);
            pend_in = 1'b1;
            if (pend_ff && !too_old) begin
               sum_in = sum_new;
               cnt_in = cnt_new;
            end
            if (mean_stop) begin
               logic [SW-1:0] s;
               s       = too_old ? sum_ff : sum_new;
               neg_in  = s[SW-1];
               quo_in  = (cnt_new == '0) ? '0 : DIV_W'(s[SW-1] ? SW'(-s) : s);
               dvs_in  = 32'(cnt_new);
               rem_in  = '0;
               step_in = '0;
            end
         end
         ST_SEL_CMP: begin
            if ($signed(mean_val) > $signed(best_ff)) begin
               best_in  = mean_val;
               pick_in  = walk_idx;
               found_in = 1'b1;
            end
            wk_in = CW'(wk_ff - 1'b1);
         end
         ST_SEL_END: begin
            if (!found_ff) begin
               code_in = RC_NONE;
            end else if (conn_ff[pick_ff] != CONN_SAT) begin
               conn_in[pick_ff] = conn_ff[pick_ff] + 1'b1;
            end
         end
         ST_DIV: begin
            rem_in  = 32'(div_ge ? rem_shift - {1'b0, dvs_ff} : rem_shift);
            quo_in  = {quo_ff[DIV_W-2:0], div_ge};
            step_in = STEP_W'(step_ff + 1'b1);
         end
         ST_RESPOND: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_code_in  = code_ff;
               rsp_entry_in = 3'(pick_ff);
               rsp_avg_in   = (func_ff == FN_SELECT && found_ff && !untried_ff)
                              ? best_ff : '0;
               rsp_spd_in   = spd_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= sample_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_conn_ff  <= MAX_CONN_RST;
         min_int_ff   <= MIN_INT_RST;
         window_ff    <= WINDOW_RST;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            status_ff[i] <= ES_NOT_TRIED;
            conn_ff[i]   <= '0;
            newest_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         max_conn_ff  <= max_conn_in;
         min_int_ff   <= min_int_in;
         window_ff    <= window_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
         conn_ff      <= conn_in;
         newest_ff    <= newest_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      id_ff        <= id_in;
      now_ff       <= now_in;
      bn_ff        <= bn_in;
      bb_ff        <= bb_in;
      us_ff        <= us_in;
      wk_ff        <= wk_in;
      slot_ff      <= slot_in;
      pend_ff      <= pend_in;
      sum_ff       <= sum_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      dvs_ff       <= dvs_in;
      step_ff      <= step_in;
      best_ff      <= best_in;
      pick_ff      <= pick_in;
      found_ff     <= found_in;
      untried_ff   <= untried_in;
      code_ff      <= code_in;
      spd_ff       <= spd_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_spd_ff   <= rsp_spd_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status_code    = rsp_code_ff;
   assign rsp_chosen_entry   = rsp_entry_ff;
   assign rsp_chosen_average = $signed(rsp_avg_ff);
   assign rsp_logged_speed   = $signed(rsp_spd_ff);

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_we)
      else $error("sample memory written while idle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES))
      else $error("entry count beyond table size");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("new word taken while one is in progress");

   a_rsp_from_respond: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESPOND))
      else $error("result raised outside the respond step");

endmodule
